### rtl/core/vst_pkg.sv
// vst_pkg: shared types and constants of the vertex status table
// holds field widths, request kind codes and the controller/datapath link structs
// depends on nothing
`default_nettype none

package vst_pkg;

   // field widths of the request and response items
   localparam int ID_W     = 16;
   localparam int STATUS_W = 2;
   localparam int MARK_W   = 16;
   localparam int POS_W    = 6;
   localparam int USED_W   = 7;

   // stream data widths, padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture the request and clear the scan
      logic scan;    // walk the filled entries
      logic finish;  // write back and load the response register
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_done;  // search has ended, hit or end of filled entries
      logic slot_free;  // response register can take a new response
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/core/vertex_status_table_unit.sv
// vertex_status_table_unit: top level of the vertex status table
// joins vst_ctrl and vst_datapath to the request and response streams; uses vst_pkg
`default_nettype none

// Associative table of up to CAPACITY vertex entries (id, search status,
// component marker), filled from position 0 upward and never emptied. An
// insert request (tuser 0) updates the entry of a known id or appends a new
// one; a lookup request (tuser 1) reads back status and marker, or zeros for
// an unknown id. Each request gives exactly one response, which also carries
// the entry count; an insert of a new id into a full table sets full_error
// and stores nothing. Requests are taken one at a time: the entries live in
// a single-port memory that is scanned one entry per cycle. A request goes
// through the accept, one read per filled entry, the compare of the last
// read, the check that sees the scan end, and the write-back, which waits
// for a free response register and loads it; a hit ends the scan early.
// The next request is accepted while the previous response still waits.
// The table needs no clearing after reset: only filled entries are read.

module vertex_status_table_unit #(
   parameter int CAPACITY = 64,  // number of table entries
   parameter int ID_BITS  = 16   // significant bits of a vertex id
) (
   input  wire                                clock,
   input  wire                                reset,
   // request stream
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // vertex_id [15:0], search_status [17:16], component_mark [33:18], zeros above
   input  wire [vst_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // kind [0]
   input  wire                                req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // position [5:0], found [6], status_out [8:7], mark_out [24:9],
   // entries_used [31:25], full_error [32], zeros above
   output logic [vst_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import vst_pkg::*;

   localparam int RSP_FIELDS_W = POS_W + 1 + STATUS_W + MARK_W + USED_W + 1;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   logic [POS_W-1:0]    position;
   logic                found;
   logic [STATUS_W-1:0] status_out;
   logic [MARK_W-1:0]   mark_out;
   logic [USED_W-1:0]   entries_used;
   logic                full_error;

   // sequencer: accept, scan, write back
   vst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // entry memory, search and response register
   vst_datapath #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_tuser),
      .req_vertex_id      (req_tdata[ID_W-1:0]),
      .req_search_status  (req_tdata[ID_W +: STATUS_W]),
      .req_component_mark (req_tdata[ID_W+STATUS_W +: MARK_W]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_position       (position),
      .rsp_found          (found),
      .rsp_status_out     (status_out),
      .rsp_mark_out       (mark_out),
      .rsp_entries_used   (entries_used),
      .rsp_full_error     (full_error)
   );

   // pack the response fields, lowest field in the lowest bits
   assign rsp_tdata = {{(RSP_TDATA_W-RSP_FIELDS_W){1'b0}},
                       full_error, entries_used, mark_out, status_out, found, position};

endmodule

`default_nettype wire

### rtl/core/vst_ctrl.sv
// vst_ctrl: sequencer of the vertex status table
// steps one request through load, scan and finish; uses vst_pkg
`default_nettype none

module vst_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  vst_pkg::dp_stat_type stat,
   output vst_pkg::ctl_cmd_type cmd
);
   import vst_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && ready_ff) begin
                  state_ff <= ST_SCAN;
                  ready_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (stat.scan_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (stat.slot_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_tready = ready_ff;

   always_comb begin
      cmd.load   = req_tvalid && ready_ff && (state_ff == ST_IDLE);
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.finish = (state_ff == ST_FINISH) && stat.slot_free;
   end

endmodule

`default_nettype wire

### rtl/core/vst_datapath.sv
// vst_datapath: entry memory, scan pipeline, fill count and response register
// follows commands of vst_ctrl; uses vst_pkg
`default_nettype none

module vst_datapath #(
   parameter int CAPACITY = 64,
   parameter int ID_BITS  = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  vst_pkg::ctl_cmd_type         cmd,
   output vst_pkg::dp_stat_type         stat,
   input  wire                          req_kind,
   input  wire [vst_pkg::ID_W-1:0]      req_vertex_id,
   input  wire [vst_pkg::STATUS_W-1:0]  req_search_status,
   input  wire [vst_pkg::MARK_W-1:0]    req_component_mark,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [vst_pkg::POS_W-1:0]    rsp_position,
   output logic                         rsp_found,
   output logic [vst_pkg::STATUS_W-1:0] rsp_status_out,
   output logic [vst_pkg::MARK_W-1:0]   rsp_mark_out,
   output logic [vst_pkg::USED_W-1:0]   rsp_entries_used,
   output logic                         rsp_full_error
);
   import vst_pkg::*;

   localparam int KEY_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int PTR_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ENTRY_W  = KEY_BITS + STATUS_W + MARK_W;

   // entry layout: id, status, mark from the top bits down
   logic [ENTRY_W-1:0] mem [CAPACITY];

   logic                kind_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [MARK_W-1:0]   mark_ff;

   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    issue_ff;
   logic                rd_pend_ff;
   logic [PTR_W-1:0]    rd_pos_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;

   logic                hit_ff;
   logic [PTR_W-1:0]    hit_pos_ff;
   logic [STATUS_W-1:0] hit_status_ff;
   logic [MARK_W-1:0]   hit_mark_ff;

   logic                rsp_valid_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                found_ff;
   logic [STATUS_W-1:0] status_out_ff;
   logic [MARK_W-1:0]   mark_out_ff;
   logic [USED_W-1:0]   used_ff;
   logic                full_ff;

   logic                issue;
   logic                match;
   logic                is_insert;
   logic                is_full;
   logic                append;
   logic                wr_en;
   logic [PTR_W-1:0]    wr_addr;
   logic [CNT_W-1:0]    fill_in;
   logic [PTR_W-1:0]    pos_sel;
   logic [31:0]         pos_wide;
   logic [31:0]         used_wide;
   logic [STATUS_W-1:0] status_sel;
   logic [MARK_W-1:0]   mark_sel;

   // scan: one read issued per cycle, compare on the registered data
   assign issue = cmd.scan && !hit_ff && (issue_ff < fill_ff);
   assign match = rd_pend_ff && !hit_ff
                  && (rd_data_ff[ENTRY_W-1 -: KEY_BITS] == key_ff);

   assign is_insert = (kind_ff == KIND_INSERT);
   assign is_full   = (fill_ff == CNT_W'(CAPACITY));
   assign append    = is_insert && !hit_ff && !is_full;
   assign wr_en     = cmd.finish && is_insert && (hit_ff || !is_full);
   assign wr_addr   = hit_ff ? hit_pos_ff : fill_ff[PTR_W-1:0];
   assign fill_in   = append ? fill_ff + CNT_W'(1) : fill_ff;

   always_comb begin
      if (hit_ff) begin
         pos_sel = hit_pos_ff;
      end else if (append) begin
         pos_sel = fill_ff[PTR_W-1:0];
      end else begin
         pos_sel = '0;
      end
      if (is_insert && (hit_ff || append)) begin
         status_sel = status_ff;
         mark_sel   = mark_ff;
      end else if (!is_insert && hit_ff) begin
         status_sel = hit_status_ff;
         mark_sel   = hit_mark_ff;
      end else begin
         status_sel = '0;
         mark_sel   = '0;
      end
   end

   assign pos_wide  = 32'(pos_sel);
   assign used_wide = 32'(fill_in);

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[issue_ff[PTR_W-1:0]];
      end
      if (wr_en) begin
         mem[wr_addr] <= {key_ff, status_ff, mark_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         issue_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
         if (cmd.load) begin
            issue_ff <= '0;
            hit_ff   <= 1'b0;
         end else begin
            if (issue) begin
               issue_ff <= issue_ff + CNT_W'(1);
            end
            if (match) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            fill_ff      <= fill_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         key_ff    <= req_vertex_id[KEY_BITS-1:0];
         status_ff <= req_search_status;
         mark_ff   <= req_component_mark;
      end
      rd_pos_ff <= issue_ff[PTR_W-1:0];
      if (match) begin
         hit_pos_ff    <= rd_pos_ff;
         hit_status_ff <= rd_data_ff[MARK_W +: STATUS_W];
         hit_mark_ff   <= rd_data_ff[MARK_W-1:0];
      end
      if (cmd.finish) begin
         pos_ff        <= pos_wide[POS_W-1:0];
         found_ff      <= hit_ff;
         status_out_ff <= status_sel;
         mark_out_ff   <= mark_sel;
         used_ff       <= used_wide[USED_W-1:0];
         full_ff       <= is_insert && !hit_ff && is_full;
      end
   end

   always_comb begin
      stat.scan_done = !rd_pend_ff && (hit_ff || (issue_ff >= fill_ff));
      stat.slot_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = pos_ff;
   assign rsp_found        = found_ff;
   assign rsp_status_out   = status_out_ff;
   assign rsp_mark_out     = mark_out_ff;
   assign rsp_entries_used = used_ff;
   assign rsp_full_error   = full_ff;

endmodule

`default_nettype wire

### rtl/core/vst_checker.sv
// vst_checker: port-level assertions for vertex_status_table_unit
// bound to the top level below; uses vst_pkg
`default_nettype none

module vst_checker #(
   parameter int CAPACITY = 64
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [vst_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import vst_pkg::*;

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped before it was taken");

   // nothing is shown right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a refused insert carries only the flag and a full count
   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |->
         rsp_tdata[31:0] == {7'(CAPACITY), 25'd0})
      else $error("full response with stray fields");

   // entry count never exceeds the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 127) || (32'(rsp_tdata[31:25]) <= 32'(CAPACITY)))
      else $error("entry count above capacity");

   // one request in flight: ready drops after an accepted request
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in work");

endmodule

bind vertex_status_table_unit vst_checker #(
   .CAPACITY (CAPACITY)
) u_vst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
